[rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BFCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfch: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define BFCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfch: next-cycle check failed");

`endif

[rtl/bfch_pkg.sv]
// ----------------------------------------------------------------------------
// bfch_pkg
// Shared types and fixed widths of the brute-force convex hull block.
// ----------------------------------------------------------------------------
package bfch_pkg;

  // widths fixed by the item formats
  localparam int FIELD_W = 16;
  localparam int PIDX_W  = 6;
  localparam int EDGE_W  = 7;

  // strobes from the sequencer to the cross-product unit
  typedef struct packed {
    logic ld_a;   // capture anchor point i
    logic ld_d;   // capture edge vector j - i
    logic ld_e;   // capture witness vector k - i
    logic mul_1;  // first product dx * ey
    logic mul_2;  // second product dy * ex
  } xu_ctl_t;

endpackage

[rtl/bfch_ram.sv]
// ----------------------------------------------------------------------------
// bfch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bfch_xunit.sv]
// ----------------------------------------------------------------------------
// bfch_xunit
// Shared cross-product unit: one subtractor pair, one multiplier used twice
// per witness, and a sign test on the registered products.
// ----------------------------------------------------------------------------
module bfch_xunit import bfch_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  xu_ctl_t                      ctl_i,
  input  logic signed [COORD_BITS-1:0] rx_i,
  input  logic signed [COORD_BITS-1:0] ry_i,
  output logic                         pos_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [COORD_BITS-1:0] xa_q, ya_q;
  logic signed [DW-1:0]         dx_q, dy_q, ex_q, ey_q;
  logic signed [PW-1:0]         p1_q, p2_q;

  logic signed [DW-1:0] sub_x, sub_y;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] cross_val;

  // offsets from the anchor point
  assign sub_x = DW'(rx_i) - DW'(xa_q);
  assign sub_y = DW'(ry_i) - DW'(ya_q);

  // one multiplier, operands picked per phase
  assign mul_a = ctl_i.mul_2 ? dy_q : dx_q;
  assign mul_b = ctl_i.mul_2 ? ex_q : ey_q;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_a) begin
      xa_q <= rx_i;
      ya_q <= ry_i;
    end
    if (ctl_i.ld_d) begin
      dx_q <= sub_x;
      dy_q <= sub_y;
    end
    if (ctl_i.ld_e) begin
      ex_q <= sub_x;
      ey_q <= sub_y;
    end
    if (ctl_i.mul_1) begin
      p1_q <= prod;
    end
    if (ctl_i.mul_2) begin
      p2_q <= prod;
    end
  end

  // strictly positive cross product
  assign cross_val = CW'(p1_q) - CW'(p2_q);
  assign pos_o     = !cross_val[CW-1] && (cross_val != '0);

endmodule

[rtl/brute_force_convex_hull.sv]
// Loading: one point item per cycle, ready again the next cycle.
// Run: the single multiplier forms two products per witness, one after the other.
// Results: one per point, through states S_ORD, S_OSH and S_OWT, held while the output is stalled.
// Reset (async, active low) empties the point set and returns to idle.
// ----------------------------------------------------------------------------
// brute_force_convex_hull
// Stores signed 2-D points and, on the closing item, finds each point's hull
// successor by testing every ordered pair against every other point.
// ----------------------------------------------------------------------------
module brute_force_convex_hull import bfch_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] x_coord_i,
  input  logic signed [FIELD_W-1:0] y_coord_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [PIDX_W-1:0]         point_index_o,
  output logic                      has_successor_o,
  output logic [PIDX_W-1:0]         successor_index_o,
  output logic [EDGE_W-1:0]         edge_count_o,
  output logic                      overflow_o,
  output logic                      last_result_o
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int PT_W  = 2 * COORD_BITS;
  localparam int SC_W  = IDX_W + 1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RDA  = 14'b00000000000010,
    S_GETA = 14'b00000000000100,
    S_RDB  = 14'b00000000001000,
    S_GETB = 14'b00000000010000,
    S_RDK  = 14'b00000000100000,
    S_DIF  = 14'b00000001000000,
    S_M1   = 14'b00000010000000,
    S_M2   = 14'b00000100000000,
    S_CMP  = 14'b00001000000000,
    S_WRS  = 14'b00010000000000,
    S_ORD  = 14'b00100000000000,
    S_OSH  = 14'b01000000000000,
    S_OWT  = 14'b10000000000000
  } state_e;

  function automatic logic idx_last(input logic [IDX_W-1:0] idx,
                                    input logic [CNT_W-1:0] cnt);
    return (CNT_W'(idx) + CNT_W'(1)) == cnt;
  endfunction

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               dropped_q, dropped_d;
  logic [IDX_W-1:0]   a_q, a_d, b_q, b_d, k_q, k_d, o_q, o_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   succ_q, succ_d;
  logic [EDGE_W-1:0]  edges_q, edges_d;

  logic [PIDX_W-1:0]  out_pidx_q, out_pidx_d;
  logic               out_has_q, out_has_d;
  logic [PIDX_W-1:0]  out_sidx_q, out_sidx_d;
  logic [EDGE_W-1:0]  out_edges_q, out_edges_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_last_q, out_last_d;

  logic               in_acc;
  logic               pass_b, next_b;
  logic               a_last, b_last, k_last, o_last;
  logic [EXT_W-1:0]   x_ext, y_ext;
  logic               pt_we;
  logic [IDX_W-1:0]   pt_raddr;
  logic [PT_W-1:0]    pt_wdata, pt_rdata;
  logic               sc_we;
  logic [SC_W-1:0]    sc_rdata;
  xu_ctl_t            xu_ctl;
  logic               xu_pos;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OWT);

  assign a_last = idx_last(a_q, cnt_q);
  assign b_last = idx_last(b_q, cnt_q);
  assign k_last = idx_last(k_q, cnt_q);
  assign o_last = idx_last(o_q, cnt_q);

  // keep the low COORD_BITS of the raw field, read back as signed
  assign x_ext    = EXT_W'($unsigned(x_coord_i));
  assign y_ext    = EXT_W'($unsigned(y_coord_i));
  assign pt_wdata = {y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};

  // point store, read at anchor, candidate or witness
  always_comb begin
    case (state_q)
      S_RDA:   pt_raddr = a_q;
      S_RDB:   pt_raddr = b_q;
      default: pt_raddr = k_q;
    endcase
  end

  bfch_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // successor store, one entry written per anchor each run
  bfch_ram #(
    .WIDTH (SC_W),
    .DEPTH (MAX_POINTS)
  ) u_sc_ram (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (a_q),
    .wdata_i ({found_q, succ_q}),
    .raddr_i (o_q),
    .rdata_o (sc_rdata)
  );

  bfch_xunit #(
    .COORD_BITS (COORD_BITS)
  ) u_xunit (
    .clk_i (clk_i),
    .ctl_i (xu_ctl),
    .rx_i  (pt_rdata[COORD_BITS-1:0]),
    .ry_i  (pt_rdata[PT_W-1:COORD_BITS]),
    .pos_o (xu_pos)
  );

  // sequencer: anchor a, candidate b, witness k
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    o_d         = o_q;
    found_d     = found_q;
    succ_d      = succ_q;
    edges_d     = edges_q;
    out_pidx_d  = out_pidx_q;
    out_has_d   = out_has_q;
    out_sidx_d  = out_sidx_q;
    out_edges_d = out_edges_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;
    pt_we       = 1'b0;
    sc_we       = 1'b0;
    xu_ctl      = '0;
    pass_b      = 1'b0;
    next_b      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_POINTS)) begin
            pt_we = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_point_i) begin
            a_d     = '0;
            edges_d = '0;
            state_d = S_RDA;
          end
        end
      end
      S_RDA: begin
        state_d = S_GETA;
      end
      S_GETA: begin
        xu_ctl.ld_a = 1'b1;
        b_d         = '0;
        found_d     = 1'b0;
        succ_d      = '0;
        state_d     = S_RDB;
      end
      S_RDB: begin
        if (b_q == a_q) begin
          next_b = 1'b1;
        end else begin
          state_d = S_GETB;
        end
      end
      S_GETB: begin
        xu_ctl.ld_d = 1'b1;
        k_d         = '0;
        state_d     = S_RDK;
      end
      S_RDK: begin
        // the pair's own endpoints are not witnesses
        if (k_q == a_q || k_q == b_q) begin
          if (k_last) begin
            pass_b = 1'b1;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end else begin
          state_d = S_DIF;
        end
      end
      S_DIF: begin
        xu_ctl.ld_e = 1'b1;
        state_d     = S_M1;
      end
      S_M1: begin
        xu_ctl.mul_1 = 1'b1;
        state_d      = S_M2;
      end
      S_M2: begin
        xu_ctl.mul_2 = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        // zero or negative rejects the candidate at once
        if (!xu_pos) begin
          next_b = 1'b1;
        end else if (k_last) begin
          pass_b = 1'b1;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_RDK;
        end
      end
      S_WRS: begin
        sc_we = 1'b1;
        if (a_last) begin
          o_d     = '0;
          state_d = S_ORD;
        end else begin
          a_d     = a_q + IDX_W'(1);
          state_d = S_RDA;
        end
      end
      S_ORD: begin
        state_d = S_OSH;
      end
      S_OSH: begin
        out_pidx_d  = PIDX_W'(o_q);
        out_has_d   = sc_rdata[IDX_W];
        out_sidx_d  = PIDX_W'(sc_rdata[IDX_W-1:0]);
        out_edges_d = edges_q;
        out_ovf_d   = dropped_q;
        out_last_d  = o_last;
        state_d     = S_OWT;
      end
      S_OWT: begin
        if (!out_stall_i) begin
          if (o_last) begin
            cnt_d     = '0;
            dropped_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            o_d     = o_q + IDX_W'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // candidate passed every witness: later ones overwrite
    if (pass_b) begin
      found_d = 1'b1;
      succ_d  = b_q;
      edges_d = edges_q + EDGE_W'(1);
      next_b  = 1'b1;
    end

    // step to the next candidate or close the anchor
    if (next_b) begin
      if (b_last) begin
        state_d = S_WRS;
      end else begin
        b_d     = b_q + IDX_W'(1);
        state_d = S_RDB;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      o_q       <= '0;
      found_q   <= 1'b0;
      succ_q    <= '0;
      edges_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      a_q       <= a_d;
      b_q       <= b_d;
      k_q       <= k_d;
      o_q       <= o_d;
      found_q   <= found_d;
      succ_q    <= succ_d;
      edges_q   <= edges_d;
    end
  end

  // result item register
  always_ff @(posedge clk_i) begin
    out_pidx_q  <= out_pidx_d;
    out_has_q   <= out_has_d;
    out_sidx_q  <= out_sidx_d;
    out_edges_q <= out_edges_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign point_index_o     = out_pidx_q;
  assign has_successor_o   = out_has_q;
  assign successor_index_o = out_sidx_q;
  assign edge_count_o      = out_edges_q;
  assign overflow_o        = out_ovf_q;
  assign last_result_o     = out_last_q;

endmodule

[rtl/bfch_checker.sv]
// ----------------------------------------------------------------------------
// bfch_checker
// Port-level checks of the hull block, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfch_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic last_point_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic last_result_o
);

  logic in_acc, out_acc;

  // handshakes on both channels
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // a stalled result item stays offered
  `BFCH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // no new point is taken while results are being delivered
  `BFCH_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o)

  // an intermediate point leaves the block ready for the next one
  `BFCH_ASSERT_NXT(a_load_rdy, clk_i, rst_ni, in_acc && !last_point_i, !in_stall_o)

  // the closing point starts the run: busy, nothing offered yet
  `BFCH_ASSERT_NXT(a_run_start, clk_i, rst_ni, in_acc && last_point_i, in_stall_o && !out_valid_o)

  // nothing follows the final result of a run
  `BFCH_ASSERT_NXT(a_run_end, clk_i, rst_ni, out_acc && last_result_o, !out_valid_o)

endmodule

bind brute_force_convex_hull bfch_checker u_bfch_checker (.*);

[dv/brute_force_convex_hull_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brute_force_convex_hull_test
// Sends sets of signed points, each closed by a last-point item, and checks
// every per-point result against an in-bench hull predictor. Covers special
// shapes, a full and an overflowing set, random sets and a long output stall.
// ----------------------------------------------------------------------------
module brute_force_convex_hull_test import bfch_pkg::*;;

  localparam int CLK_PERIOD   = 8;
  localparam int MAX_POINTS   = 32;
  localparam int COORD_BITS   = 16;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 50;
  // room for two full sets, the random sets and the stalls
  localparam int CYCLE_LIMIT  = 4000000;
  localparam logic [FIELD_W-1:0] CORNER_VALS [4] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF};
  localparam logic [FIELD_W-1:0] COORD_MIN = 16'h8000;
  localparam logic [FIELD_W-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [FIELD_W-1:0] MINUS_ONE = 16'hFFFF;

  typedef enum {SHAPE_SPREAD, SHAPE_CLUSTER, SHAPE_CONVEX, SHAPE_CORNER} set_shape_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [PIDX_W-1:0] point_index;
    logic              has_successor;
    logic [PIDX_W-1:0] successor_index;
    logic [EDGE_W-1:0] edge_count;
    logic              overflow;
    logic              last_result;
  } hull_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [FIELD_W-1:0] x_coord_i = '0;
  logic signed [FIELD_W-1:0] y_coord_i = '0;
  logic                      last_point_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [PIDX_W-1:0]         point_index_o;
  logic                      has_successor_o;
  logic [PIDX_W-1:0]         successor_index_o;
  logic [EDGE_W-1:0]         edge_count_o;
  logic                      overflow_o;
  logic                      last_result_o;

  // predictor state: the points of the open set
  longint       set_x [MAX_POINTS];
  longint       set_y [MAX_POINTS];
  int           set_size = 0;
  bit           set_dropped = 1'b0;
  hull_result_t hull_expect_q [$];

  int  error_count = 0;
  int  points_sent = 0;
  int  burst_left = 0;
  int  cycle_count = 0;
  bit  hold_off_req = 1'b0;
  int  hold_left = 0;
  int  stall_phase_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  brute_force_convex_hull u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .x_coord_i         (x_coord_i),
    .y_coord_i         (y_coord_i),
    .last_point_i      (last_point_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .point_index_o     (point_index_o),
    .has_successor_o   (has_successor_o),
    .successor_index_o (successor_index_o),
    .edge_count_o      (edge_count_o),
    .overflow_o        (overflow_o),
    .last_result_o     (last_result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // sign-extend the coordinate from its low COORD_BITS bits
  function automatic longint coord_value(logic [FIELD_W-1:0] raw);
    logic signed [COORD_BITS-1:0] low_bits;
    low_bits = raw[COORD_BITS-1:0];
    return longint'(low_bits);
  endfunction

  // edge a->b is a hull edge when every other point lies strictly to its left
  function automatic bit is_hull_edge(int a, int b);
    longint dx, dy, cr;
    dx = set_x[b] - set_x[a];
    dy = set_y[b] - set_y[a];
    for (int c = 0; c < set_size; c++) begin
      if (c == a || c == b) continue;
      cr = dx * (set_y[c] - set_y[a]) - dy * (set_x[c] - set_x[a]);
      if (cr <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // store one accepted point; on the closing item queue one result per point
  function automatic void hull_accept(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                      logic last);
    int           succ [MAX_POINTS];
    bit           found [MAX_POINTS];
    int           edges;
    hull_result_t res;
    if (set_size < MAX_POINTS) begin
      set_x[set_size] = coord_value(x);
      set_y[set_size] = coord_value(y);
      set_size++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    edges = 0;
    for (int a = 0; a < set_size; a++) begin
      found[a] = 1'b0;
      succ[a]  = 0;
      for (int b = 0; b < set_size; b++) begin
        if (a != b && is_hull_edge(a, b)) begin
          found[a] = 1'b1;
          succ[a]  = b;
          edges++;
        end
      end
    end
    for (int a = 0; a < set_size; a++) begin
      res.point_index     = PIDX_W'(a);
      res.has_successor   = found[a];
      res.successor_index = found[a] ? PIDX_W'(succ[a]) : '0;
      res.edge_count      = EDGE_W'(edges);
      res.overflow        = set_dropped;
      res.last_result     = (a + 1 == set_size);
      hull_expect_q.push_back(res);
    end
    set_size    = 0;
    set_dropped = 1'b0;
  endfunction

  // send one item in bursts with random gaps in between
  task automatic send_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i) in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hull_accept(x, y, last);
    points_sent++;
  endtask

  // build a set of n points of the given shape and send it, closed by its last
  task automatic send_set(int n, set_shape_e shape);
    logic [FIELD_W-1:0] xs [MAX_POINTS];
    logic [FIELD_W-1:0] ys [MAX_POINTS];
    logic [FIELD_W-1:0] tmp;
    int  u, sx, sy, ox, oy, yv, j;
    bit  flip, swap;
    sx   = $urandom_range(1, 900);
    sy   = $urandom_range(1, 100);
    ox   = int'($urandom_range(0, 36000)) - 18000;
    oy   = int'($urandom_range(0, 39935)) - 32768;
    flip = 1'($urandom_range(0, 1));
    swap = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_SPREAD: begin
          xs[i] = FIELD_W'($urandom());
          ys[i] = FIELD_W'($urandom());
        end
        SHAPE_CLUSTER: begin
          xs[i] = FIELD_W'(int'($urandom_range(0, 6)) - 3);
          ys[i] = FIELD_W'(int'($urandom_range(0, 6)) - 3);
        end
        SHAPE_CONVEX: begin
          // points on a parabola are all hull vertices
          u  = i - n / 2;
          yv = u * u * sy + oy;
          if (flip) yv = -1 - yv;
          xs[i] = FIELD_W'(u * sx + ox);
          ys[i] = FIELD_W'(yv);
          if (swap) begin
            tmp   = xs[i];
            xs[i] = ys[i];
            ys[i] = tmp;
          end
        end
        default: begin
          xs[i] = CORNER_VALS[$urandom_range(0, 3)];
          ys[i] = CORNER_VALS[$urandom_range(0, 3)];
        end
      endcase
    end
    // shuffle so that hull order differs from index order
    for (int i = n - 1; i > 0; i--) begin
      j     = $urandom_range(0, i);
      tmp   = xs[i];
      xs[i] = xs[j];
      xs[j] = tmp;
      tmp   = ys[i];
      ys[i] = ys[j];
      ys[j] = tmp;
    end
    for (int i = 0; i < n; i++) send_point(xs[i], ys[i], i == n - 1);
  endtask

  // single point, pairs, extremes, collinear and duplicate points
  task automatic test_directed_shapes();
    send_point(16'd0, 16'd0, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(16'd5, 16'd5, 1'b0);
    send_point(16'd5, 16'd5, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(16'd0, COORD_MAX, 1'b1);
    // clockwise square on the corners of the range
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b1);
    send_point(MINUS_ONE, MINUS_ONE, 1'b0);
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd1, 16'd1, 1'b1);
    // square with an inner point and a repeated corner
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd100, 16'd0, 1'b0);
    send_point(16'd100, 16'd100, 1'b0);
    send_point(16'd0, 16'd100, 1'b0);
    send_point(16'd50, 16'd50, 1'b0);
    send_point(16'd100, 16'd100, 1'b1);
    // a point in the middle of a hull edge
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd2, 16'd0, 1'b0);
    send_point(16'd4, 16'd0, 1'b0);
    send_point(16'd2, 16'd3, 1'b1);
  endtask

  // a set exactly at capacity with every point on the hull
  task automatic test_full_capacity();
    send_set(MAX_POINTS, SHAPE_CONVEX);
  endtask

  // points past capacity are dropped; a dropped item still closes the set
  task automatic test_overflow_drop();
    for (int i = 0; i < MAX_POINTS + 2; i++) begin
      send_point(FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b0);
    end
    send_point(FIELD_W'($urandom()), FIELD_W'($urandom()), 1'b1);
    send_set(3, SHAPE_SPREAD);
  endtask

  // random sets, mostly small, of every shape
  task automatic test_random_sets();
    int target, pick, n;
    target = points_sent + RANDOM_ITEMS;
    while (points_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(1, 6);
      else if (pick < 95) n = $urandom_range(7, 12);
      else n = $urandom_range(13, 20);
      send_set(n, set_shape_e'($urandom_range(0, 3)));
    end
  endtask

  // long receiver hold-off while sets keep coming
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    for (int s = 0; s < 6; s++) begin
      send_set($urandom_range(2, 5), set_shape_e'($urandom_range(0, 3)));
    end
  endtask

  // receiver stall pattern, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = stall_mode_e'($urandom_range(0, 2));
        stall_phase_left = $urandom_range(20, 200);
      end
      stall_phase_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin
    hull_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hull_expect_q.size() == 0) begin
        $error("result for point %0d with none expected", point_index_o);
        error_count++;
      end else begin
        want = hull_expect_q.pop_front();
        check_field("point_index", int'(want.point_index), int'(point_index_o));
        check_field("has_successor", int'(want.has_successor), int'(has_successor_o));
        check_field("successor_index", int'(want.successor_index),
                    int'(successor_index_o));
        check_field("edge_count", int'(want.edge_count), int'(edge_count_o));
        check_field("overflow", int'(want.overflow), int'(overflow_o));
        check_field("last_result", int'(want.last_result), int'(last_result_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed_shapes();
    test_full_capacity();
    test_overflow_drop();
    test_random_sets();
    test_output_backpressure();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (hull_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
